// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by ldswe_issue.
// Both forms are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("concurrent assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/ldswe_pkg.sv =====
`default_nettype none

package ldswe_pkg;

  localparam int DATA_W      = 16;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 8;
  localparam int GAMMA_DEPTH = 256;
  localparam int LE_W        = 5;

  // Latch-enable clock counts of the driver commands.
  localparam logic [LE_W-1:0] CMD_NONE       = 5'd0;
  localparam logic [LE_W-1:0] CMD_DATA_LATCH = 5'd1;
  localparam logic [LE_W-1:0] CMD_PREACTIVE  = 5'd14;
  localparam logic [LE_W-1:0] LE_MAX         = 5'd16;

  typedef enum logic [1:0] {
    OP_PIXEL    = 2'd0,
    OP_TABLE_WR = 2'd1,
    OP_REG_WR   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIXEL,
    ST_PRE,
    ST_REG
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_t;

  typedef struct packed {
    logic              use_mem;
    logic [DATA_W-1:0] data;
    logic [LE_W-1:0]   le_n;
    logic              last;
  } beat_t;

  // Data bit i goes to word bit 2i.
  function automatic logic [WORD_W-1:0] spread16(input logic [DATA_W-1:0] v);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < DATA_W; i++) begin
      w[2*i] = v[i];
    end
    return w;
  endfunction

  // Odd bits 1, 3, ..., 2n-1; a count above 16 sets every odd bit.
  function automatic logic [WORD_W-1:0] le_mask(input logic [LE_W-1:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W; i++) begin
      m[2*i+1] = (LE_W'(i) < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ldswe_if.sv =====
`default_nettype none

interface ldswe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        latch;
  logic [7:0]  table_index;
  logic [15:0] table_value;
  logic [5:0]  command_code;
  logic [15:0] reg_value_a;
  logic [15:0] reg_value_b;
  logic [15:0] reg_value_c;

  modport source (
    output valid, operation, red, green, blue, latch, table_index, table_value,
           command_code, reg_value_a, reg_value_b, reg_value_c,
    input  ready
  );
  modport sink (
    input  valid, operation, red, green, blue, latch, table_index, table_value,
           command_code, reg_value_a, reg_value_b, reg_value_c,
    output ready
  );
endinterface

interface ldswe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last;

  modport source (output valid, out_word, last, input ready);
  modport sink (input valid, out_word, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ldswe_gamma_mem.sv =====
`default_nettype none

module ldswe_gamma_mem (
  input  wire logic                          clk,
  input  wire ldswe_pkg::wr_t                wr,
  input  wire ldswe_pkg::rd_t                rd,
  output logic [ldswe_pkg::DATA_W-1:0]       q
);

  logic [ldswe_pkg::DATA_W-1:0] mem [ldswe_pkg::GAMMA_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data holds while no read is issued, so a stalled word keeps its value.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      q <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ldswe_issue.sv =====
`default_nettype none
`include "assert_macros.svh"

module ldswe_issue #(
  parameter int CHAIN_LENGTH = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  ldswe_in_if.sink               items,
  input  wire logic              advance,
  output ldswe_pkg::beat_t       beat,
  output logic                   beat_valid,
  output ldswe_pkg::rd_t         rd,
  output ldswe_pkg::wr_t         wr
);

  localparam int CHIP_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
  localparam logic [CHIP_W-1:0] LAST_CHIP = CHIP_W'(CHAIN_LENGTH - 1);

  ldswe_pkg::state_t state, state_next;
  logic [1:0]        pos;
  logic [CHIP_W-1:0] chip;

  logic [7:0]  red, green, blue;
  logic        latch, black;
  logic [15:0] va, vb, vc;
  logic [ldswe_pkg::LE_W-1:0] first_cnt, second_cnt, third_cnt;
  logic [ldswe_pkg::LE_W-1:0] first_cnt_next, second_cnt_next, third_cnt_next;
  logic [5:0]  cmd_hi, rem_mid, sec_raw;

  logic accept, step, last_chip;

  assign accept    = items.valid && items.ready;
  assign step      = beat_valid && advance;
  assign last_chip = (chip == LAST_CHIP);

  assign items.ready = (state == ldswe_pkg::ST_IDLE) || (step && beat.last);

  // Spread the command's clocks over the last chip's three words, 16 at most on each.
  always_comb begin
    cmd_hi  = items.command_code - 6'd32;
    rem_mid = (items.command_code > 6'd32) ? 6'd32 : items.command_code;
    sec_raw = rem_mid - 6'd16;
    if (items.command_code <= 6'd32) begin
      first_cnt_next = ldswe_pkg::CMD_NONE;
    end else if (cmd_hi > 6'd16) begin
      first_cnt_next = ldswe_pkg::LE_MAX;
    end else begin
      first_cnt_next = cmd_hi[4:0];
    end
    second_cnt_next = (rem_mid > 6'd16) ? sec_raw[4:0] : ldswe_pkg::CMD_NONE;
    third_cnt_next  = (rem_mid > 6'd16) ? ldswe_pkg::LE_MAX : rem_mid[4:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ldswe_pkg::ST_IDLE: begin
        state_next = ldswe_pkg::ST_IDLE;
      end
      ldswe_pkg::ST_PIXEL: begin
        if (step && pos == 2'd2) state_next = ldswe_pkg::ST_IDLE;
      end
      ldswe_pkg::ST_PRE: begin
        if (step) state_next = ldswe_pkg::ST_REG;
      end
      ldswe_pkg::ST_REG: begin
        if (step && last_chip && pos == 2'd2) state_next = ldswe_pkg::ST_IDLE;
      end
      default: begin
        state_next = ldswe_pkg::ST_IDLE;
      end
    endcase
    if (accept) begin
      case (items.operation)
        ldswe_pkg::OP_PIXEL:  state_next = ldswe_pkg::ST_PIXEL;
        ldswe_pkg::OP_REG_WR: state_next = ldswe_pkg::ST_PRE;
        default:              state_next = ldswe_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldswe_pkg::ST_IDLE;
      pos   <= 2'd0;
      chip  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        pos  <= 2'd0;
        chip <= '0;
      end else if (step) begin
        case (state)
          ldswe_pkg::ST_PIXEL: begin
            pos <= pos + 2'd1;
          end
          ldswe_pkg::ST_REG: begin
            if (pos == 2'd2) begin
              pos  <= 2'd0;
              chip <= chip + CHIP_W'(1);
            end else begin
              pos <= pos + 2'd1;
            end
          end
          default: begin
            pos <= 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red        <= items.red;
      green      <= items.green;
      blue       <= items.blue;
      latch      <= items.latch;
      black      <= ((items.red | items.green | items.blue) == 8'd0);
      va         <= items.reg_value_a;
      vb         <= items.reg_value_b;
      vc         <= items.reg_value_c;
      first_cnt  <= first_cnt_next;
      second_cnt <= second_cnt_next;
      third_cnt  <= third_cnt_next;
    end
  end

  always_comb begin
    beat_valid   = (state != ldswe_pkg::ST_IDLE);
    beat.use_mem = 1'b0;
    beat.data    = '0;
    beat.le_n    = ldswe_pkg::CMD_NONE;
    beat.last    = 1'b0;
    case (state)
      ldswe_pkg::ST_PIXEL: begin
        beat.use_mem = !black;
        beat.last    = (pos == 2'd2);
        if (pos == 2'd2 && latch) beat.le_n = ldswe_pkg::CMD_DATA_LATCH;
      end
      ldswe_pkg::ST_PRE: begin
        beat.le_n = ldswe_pkg::CMD_PREACTIVE;
      end
      ldswe_pkg::ST_REG: begin
        case (pos)
          2'd0: begin
            beat.data = vc;
            if (last_chip) beat.le_n = first_cnt;
          end
          2'd1: begin
            beat.data = vb;
            if (last_chip) beat.le_n = second_cnt;
          end
          default: begin
            beat.data = va;
            if (last_chip) beat.le_n = third_cnt;
            beat.last = last_chip;
          end
        endcase
      end
      default: begin
        beat_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd.en = step && beat.use_mem;
    case (pos)
      2'd0:    rd.addr = red;
      2'd1:    rd.addr = green;
      default: rd.addr = blue;
    endcase
    // A table write goes straight to memory in the cycle it is accepted.
    wr.en   = accept && (items.operation == ldswe_pkg::OP_TABLE_WR);
    wr.addr = items.table_index;
    wr.data = items.table_value;
  end

  `ASSERT_NEXT(a_stall_holds, clk, rst, beat_valid && !advance,
               $stable(state) && $stable(pos) && $stable(chip))
  `ASSERT_PROP(a_chip_bound, clk, rst, (state == ldswe_pkg::ST_REG) |-> (chip <= LAST_CHIP))
  `ASSERT_PROP(a_read_pixel, clk, rst, rd.en |-> (state == ldswe_pkg::ST_PIXEL && !black))

endmodule

`default_nettype wire

// ===== rtl/core/ldswe_out_stage.sv =====
`default_nettype none

module ldswe_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ldswe_pkg::beat_t              beat,
  input  wire logic                          beat_valid,
  input  wire logic [ldswe_pkg::DATA_W-1:0]  mem_q,
  output logic                               advance,
  ldswe_out_if.source                        words
);

  logic             b_valid;
  ldswe_pkg::beat_t b_beat;
  logic [ldswe_pkg::DATA_W-1:0] data_sel;

  assign advance = !b_valid || words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= beat_valid;
    end
  end

  // The gamma read is issued on the same edge, so mem_q lines up with b_beat.
  always_ff @(posedge clk) begin
    if (advance && beat_valid) begin
      b_beat <= beat;
    end
  end

  assign data_sel       = b_beat.use_mem ? mem_q : b_beat.data;
  assign words.valid    = b_valid;
  assign words.out_word = ldswe_pkg::spread16(data_sel) | ldswe_pkg::le_mask(b_beat.le_n);
  assign words.last     = b_beat.last;

endmodule

`default_nettype wire

// ===== rtl/core/led_driver_serial_word_encoder.sv =====
`default_nettype none

// Word encoder for a chain of LED driver chips. Each transaction on items yields a run of
// 32-bit words on words, the last one flagged: three for a pixel (red, green, blue through
// the gamma table, or zero for an all-black pixel), none for a table write, and
// 1 + 3*CHAIN_LENGTH for a register write. One word leaves per cycle while words.ready
// is high; a table write goes to the gamma table when accepted. The rate is set by the
// output channel, which carries one word per cycle unless the sink stalls it; the gamma
// memory's single read port keeps up because it is read at most once per word. The next
// transaction is taken in the cycle the current run issues its last word. The gamma
// table has no reset: load every entry a pixel will use before sending pixels.
module led_driver_serial_word_encoder #(
  parameter int CHAIN_LENGTH = 3
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ldswe_in_if.sink    items,
  ldswe_out_if.source words
);

  ldswe_pkg::beat_t beat;
  logic             beat_valid;
  logic             advance;
  ldswe_pkg::rd_t   rd;
  ldswe_pkg::wr_t   wr;
  logic [ldswe_pkg::DATA_W-1:0] mem_q;

  ldswe_issue #(
    .CHAIN_LENGTH(CHAIN_LENGTH)
  ) u_issue (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .advance    (advance),
    .beat       (beat),
    .beat_valid (beat_valid),
    .rd         (rd),
    .wr         (wr)
  );

  ldswe_gamma_mem u_gamma (
    .clk (clk),
    .wr  (wr),
    .rd  (rd),
    .q   (mem_q)
  );

  ldswe_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .beat_valid (beat_valid),
    .mem_q      (mem_q),
    .advance    (advance),
    .words      (words)
  );

endmodule

`default_nettype wire
